[hdl/chks_pkg.sv]
// Shared types and constants for the chained hash key store.
`timescale 1ns / 1ps
package chks_pkg;
    localparam int DEF_BUCKETS = 128;
    localparam int DEF_POOL    = 256;
    localparam int KIND_W      = 2;
    localparam int KEY_W       = 31;
    localparam int VAL_W       = 32;
    localparam int STATUS_W    = 3;
    localparam int HASH_STEPS  = 2;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_HEAD_RD,
        S_HEAD_WT,
        S_ENT_RD,
        S_ENT_CHK,
        S_DONE
    } t_state;
endpackage

[hdl/chks_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module chks_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/chained_hash_key_store_top.sv]
// Top level of the chained hash key store.
//
// Input channel: i_in_valid / o_in_stall carry one request beat (kind, key,
// value). Output channel: o_out_valid / i_out_stall carry one status beat per
// request. Kind insert links a new pool slot at the head of bucket key mod
// NUM_BUCKETS; delete unlinks the newest matching entry; search (and the
// unused kind code) reports found or not found.
// One request is in work at a time. From accept, a request passes through
// bucket hashing (reciprocal multiply, then remainder) and the head and free
// stack read; insert then loads its result into the output register. Delete
// and search first walk the chain, one entry read and one entry check per
// entry visited, until an entry matches or the chain ends.
// The next request is taken in the cycle after the result is loaded.
// The chain walk through the entry RAM, one read per entry, sets the rate.
// o_in_stall is high from accept until the result is loaded into the output
// register; a new request is taken while that result still waits.
// While i_out_stall holds a result, the next result waits in its last state.
// Reset (i_rst_n low, synchronous) empties every bucket through per-bucket
// valid bits and marks the whole pool free; no clearing pass is needed.
`timescale 1ns / 1ps
module chained_hash_key_store_top #(
    parameter int NUM_BUCKETS  = chks_pkg::DEF_BUCKETS,
    parameter int POOL_ENTRIES = chks_pkg::DEF_POOL
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [chks_pkg::KIND_W-1:0]   i_kind,
    input  logic [chks_pkg::KEY_W-1:0]    i_key,
    input  logic signed [chks_pkg::VAL_W-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [chks_pkg::STATUS_W-1:0] o_status
);
    import chks_pkg::*;

    localparam int HW     = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SW     = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int LW     = $clog2(POOL_ENTRIES + 1);
    localparam int EW     = VAL_W + KEY_W + LW;
    localparam int RSH    = KEY_W + $clog2(NUM_BUCKETS);
    localparam int PW     = KEY_W + 32;
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << RSH) + 64'(NUM_BUCKETS - 1)) / 64'(NUM_BUCKETS);
    localparam logic [31:0]   RCP       = RCP_FULL[31:0];
    localparam logic [LW-1:0] NULL_LINK = LW'(POOL_ENTRIES);
    localparam logic [HW-1:0] NB_LO     = HW'(NUM_BUCKETS);

    t_state r_state, n_state;

    logic [KIND_W-1:0]   r_kind;
    logic [KEY_W-1:0]    r_key;
    logic [VAL_W-1:0]    r_value;
    logic [KEY_W-1:0]    r_q, n_q;
    logic [HW-1:0]       r_rem, n_rem;
    logic [2:0]          r_step;
    logic [LW-1:0]       r_cur, n_cur;
    logic [LW-1:0]       r_prev, n_prev;
    logic [KEY_W-1:0]    r_prev_key, n_prev_key;
    logic [VAL_W-1:0]    r_prev_val, n_prev_val;
    logic [LW-1:0]       r_count, n_count;
    logic [LW-1:0]       r_low, n_low;
    logic [NUM_BUCKETS-1:0] r_head_vld, n_head_vld;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [STATUS_W-1:0] r_out_status;

    logic            head_we, ent_we, free_we;
    logic [HW-1:0]   head_waddr;
    logic [LW-1:0]   head_wdata, head_rdata, head_link;
    logic [SW-1:0]   ent_waddr, ent_raddr, free_waddr, free_raddr;
    logic [EW-1:0]   ent_wdata, ent_rdata;
    logic [SW-1:0]   free_wdata, free_rdata, slot;
    logic [LW-1:0]   cnt_m1, ent_link;
    logic [KEY_W-1:0] ent_key;
    logic [VAL_W-1:0] ent_val;
    logic [PW-1:0]   hash_prod;
    logic [HW-1:0]   hash_qn;
    logic            in_acc, out_load, hit, is_ins, is_del;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign is_ins   = (r_kind == KIND_INSERT);
    assign is_del   = (r_kind == KIND_DELETE);
    assign cnt_m1   = r_count - LW'(1);
    assign head_link = r_head_vld[r_rem] ? head_rdata : NULL_LINK;
    assign {ent_val, ent_key, ent_link} = ent_rdata;
    assign hit      = (ent_key == r_key);
    assign slot     = (r_count > r_low) ? free_rdata : cnt_m1[SW-1:0];
    assign ent_raddr  = r_cur[SW-1:0];
    assign free_raddr = cnt_m1[SW-1:0];
    assign hash_prod  = PW'(r_key) * PW'(RCP);
    assign hash_qn    = r_q[HW-1:0] * NB_LO;

    chks_ram #(.W(LW), .D(NUM_BUCKETS)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_raddr(r_rem), .o_rdata(head_rdata)
    );

    chks_ram #(.W(EW), .D(POOL_ENTRIES)) u_entry (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(ent_waddr), .i_wdata(ent_wdata),
        .i_raddr(ent_raddr), .o_rdata(ent_rdata)
    );

    chks_ram #(.W(SW), .D(POOL_ENTRIES)) u_free (
        .i_clk(i_clk), .i_we(free_we), .i_waddr(free_waddr), .i_wdata(free_wdata),
        .i_raddr(free_raddr), .o_rdata(free_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_HASH;
            end
            S_HASH: begin
                if (r_step == 3'(HASH_STEPS - 1)) n_state = S_HEAD_RD;
            end
            S_HEAD_RD: n_state = S_HEAD_WT;
            S_HEAD_WT: begin
                if (is_ins) n_state = S_DONE;
                else        n_state = S_ENT_RD;
            end
            S_ENT_RD: begin
                if (r_cur == NULL_LINK) n_state = S_DONE;
                else                    n_state = S_ENT_CHK;
            end
            S_ENT_CHK: begin
                if (hit) n_state = S_DONE;
                else     n_state = S_ENT_RD;
            end
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_q        = r_q;
        n_rem      = r_rem;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_prev_key = r_prev_key;
        n_prev_val = r_prev_val;
        n_count    = r_count;
        n_low      = r_low;
        n_head_vld = r_head_vld;
        n_status   = r_status;
        head_we    = 1'b0;
        head_waddr = r_rem;
        head_wdata = LW'(slot);
        ent_we     = 1'b0;
        ent_waddr  = slot;
        ent_wdata  = {r_value, r_key, head_link};
        free_we    = 1'b0;
        free_waddr = r_count[SW-1:0];
        free_wdata = r_cur[SW-1:0];
        case (r_state)
            S_IDLE: begin
                n_rem = '0;
            end
            S_HASH: begin
                if (r_step == 3'(HASH_STEPS - 1)) n_rem = r_key[HW-1:0] - hash_qn;
                else                               n_q   = KEY_W'(hash_prod >> RSH);
            end
            S_HEAD_WT: begin
                n_cur  = head_link;
                n_prev = NULL_LINK;
                if (is_ins) begin
                    if (r_count == '0) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status   = ST_INSERTED;
                        ent_we     = 1'b1;
                        head_we    = 1'b1;
                        n_head_vld[r_rem] = 1'b1;
                        n_count    = cnt_m1;
                        if (cnt_m1 < r_low) n_low = cnt_m1;
                    end
                end
            end
            S_ENT_RD: begin
                if (r_cur == NULL_LINK) n_status = ST_NOT_FOUND;
            end
            S_ENT_CHK: begin
                if (hit) begin
                    if (is_del) begin
                        n_status = ST_DELETED;
                        if (r_prev == NULL_LINK) begin
                            head_we    = 1'b1;
                            head_wdata = ent_link;
                        end else begin
                            ent_we    = 1'b1;
                            ent_waddr = r_prev[SW-1:0];
                            ent_wdata = {r_prev_val, r_prev_key, ent_link};
                        end
                        if (r_count < NULL_LINK) begin
                            free_we = 1'b1;
                            n_count = r_count + LW'(1);
                        end
                    end else begin
                        n_status = ST_FOUND;
                    end
                end else begin
                    n_prev     = r_cur;
                    n_prev_key = ent_key;
                    n_prev_val = ent_val;
                    n_cur      = ent_link;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_count     <= NULL_LINK;
            r_low       <= NULL_LINK;
            r_head_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_low      <= n_low;
            r_head_vld <= n_head_vld;
            if (r_state == S_HASH) r_step <= r_step + 3'd1;
            else                   r_step <= '0;
            if (out_load)          r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind  <= i_kind;
            r_key   <= i_key;
            r_value <= i_value;
        end
        r_q        <= n_q;
        r_rem      <= n_rem;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_prev_key <= n_prev_key;
        r_prev_val <= n_prev_val;
        r_status   <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (out_load) r_out_status <= r_status;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
endmodule

[hdl/chks_check.sv]
// Port checker for the chained hash key store, bound to the top level.
`timescale 1ns / 1ps
module chks_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [chks_pkg::STATUS_W-1:0] o_status
);
    import chks_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status))
        else $error("stalled result beat changed");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_INSERTED || o_status == ST_FULL ||
                         o_status == ST_DELETED || o_status == ST_NOT_FOUND ||
                         o_status == ST_FOUND))
        else $error("status code out of range");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request beat taken while one is in work");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> ##1 !$rose(o_out_valid))
        else $error("result beat appeared too early");
endmodule

bind chained_hash_key_store_top chks_check u_chks_check (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_stall(o_in_stall), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_status(o_status)
);
